FILE: rtl/core/triangle_projected_setup_core_macros.svh
// assertion macros shared by the triangle setup core
`ifndef TRIANGLE_PROJECTED_SETUP_CORE_MACROS_SVH
`define TRIANGLE_PROJECTED_SETUP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tps implication check failed");
`define TPS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tps next-cycle check failed");
`else
`define TPS_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define TPS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/core/tps_pkg.sv
// shared constants and types for the triangle setup core
`default_nettype none
package tps_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    localparam int AXIS_W = 2;
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int NORM_QB   = 15;
    localparam int SM_W      = 31;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = 32;

    localparam int INV_W     = 32;
    localparam int INV_QB    = 34;
    localparam int INV_SHIFT = 33;
    localparam logic [INV_W-1:0] INV_POS_LIM = 32'h7fff_ffff;
    localparam logic [INV_W-1:0] INV_NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/tps_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module tps_sqrt_pipe #(
    parameter int SW = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  tps_pkg::pipe_ctl_t                 ctl,
    input  logic [tps_pkg::SUM_W-1:0]          radicand,
    input  logic [SW-1:0]                      side,
    output logic                               out_valid,
    output logic [tps_pkg::ROOT_W-1:0]         root,
    output logic [SW-1:0]                      side_out
);

    localparam int NS = tps_pkg::ROOT_W;
    localparam int RW = tps_pkg::SUM_W + 2;

    logic            valid_reg [NS];
    logic [SW-1:0]   side_reg  [NS];
    logic [NS-1:0]   root_reg  [NS];
    logic [RW-1:0]   rem_reg   [NS-1];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int K = NS - 1 - g;
        logic          valid_src;
        logic [SW-1:0] side_src;
        logic [NS-1:0] root_src;
        logic [RW-1:0] rem_src;
        logic [NS-1:0] root_next;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;

        if (g == 0) begin : g_head
            assign valid_src = ctl.valid;
            assign side_src  = side;
            assign root_src  = '0;
            assign rem_src   = RW'(radicand);
        end else begin : g_body
            assign valid_src = valid_reg[g-1];
            assign side_src  = side_reg[g-1];
            assign root_src  = root_reg[g-1];
            assign rem_src   = rem_reg[g-1];
        end

        // (root + 2^k)^2 - root^2 = root*2^(k+1) + 4^k
        assign trial = (RW'(root_src) << (K + 1)) | (RW'(1) << (2 * K));

        always_comb
        begin
            rem_next  = rem_src;
            root_next = root_src;
            if (rem_src >= trial)
            begin
                rem_next     = rem_src - trial;
                root_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.advance)
                valid_reg[g] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance && valid_src)
            begin
                side_reg[g] <= side_src;
                root_reg[g] <= root_next;
            end
        end

        if (g < NS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ctl.advance && valid_src)
                    rem_reg[g] <= rem_next;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign root      = root_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
`default_nettype wire

FILE: rtl/core/tps_div_pipe.sv
// pipelined restoring divider, several lanes sharing one item, one quotient bit per stage
`default_nettype none
module tps_div_pipe #(
    parameter int LANES = 1,
    parameter int DW    = 8,
    parameter int QB    = 8,
    parameter int SW    = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  tps_pkg::pipe_ctl_t             ctl,
    input  logic [LANES-1:0][DW+QB-1:0]    num,
    input  logic [LANES-1:0][DW-1:0]       den,
    input  logic [SW-1:0]                  side,
    output logic                           out_valid,
    output logic [LANES-1:0][QB-1:0]       quo,
    output logic [SW-1:0]                  side_out
);

    localparam int RW = DW + QB;

    logic                       valid_reg [QB];
    logic [SW-1:0]              side_reg  [QB];
    logic [LANES-1:0][QB-1:0]   quo_reg   [QB];
    logic [LANES-1:0][RW-1:0]   rem_reg   [QB-1];
    logic [LANES-1:0][DW-1:0]   den_reg   [QB-1];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int K = QB - 1 - g;
        logic                     valid_src;
        logic [SW-1:0]            side_src;
        logic [LANES-1:0][QB-1:0] quo_src;
        logic [LANES-1:0][RW-1:0] rem_src;
        logic [LANES-1:0][DW-1:0] den_src;
        logic [LANES-1:0][QB-1:0] quo_next;
        logic [LANES-1:0][RW-1:0] rem_next;

        if (g == 0) begin : g_head
            assign valid_src = ctl.valid;
            assign side_src  = side;
            assign quo_src   = '0;
            assign rem_src   = num;
            assign den_src   = den;
        end else begin : g_body
            assign valid_src = valid_reg[g-1];
            assign side_src  = side_reg[g-1];
            assign quo_src   = quo_reg[g-1];
            assign rem_src   = rem_reg[g-1];
            assign den_src   = den_reg[g-1];
        end

        always_comb
        begin
            logic [RW-1:0] trial;
            trial    = '0;
            rem_next = rem_src;
            quo_next = quo_src;
            for (int l = 0; l < LANES; l++)
            begin
                trial = RW'(den_src[l]) << K;
                if (rem_src[l] >= trial)
                begin
                    rem_next[l]    = rem_src[l] - trial;
                    quo_next[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (ctl.advance)
                valid_reg[g] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance && valid_src)
            begin
                side_reg[g] <= side_src;
                quo_reg[g]  <= quo_next;
            end
        end

        if (g < QB - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ctl.advance && valid_src)
                begin
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_src;
                end
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign quo       = quo_reg[QB-1];
    assign side_out  = side_reg[QB-1];

endmodule
`default_nettype wire

FILE: rtl/core/triangle_projected_setup_core.sv
// triangle setup: unit normal, projection axes and inverse edge matrix, fully pipelined
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_ready | v0_x .. v2_z, signed Q16.16
//   out     | out_valid/out_ready | normal_x/y/z, proj_u, proj_v, inv_m00..11, degenerate
//
// one item accepted per cycle while the pipeline is not held
// from accept to out_valid: 8 setup stages, 32 root stages, 15 normal divide stages,
// 34 inverse divide stages and the output register
// the whole pipeline holds while out_valid is high and out_ready is low
// reset clears only the valid bits, no clearing pass
`default_nettype none
`include "triangle_projected_setup_core_macros.svh"
module triangle_projected_setup_core #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          v0_x,
    input  logic signed [COORD_WIDTH-1:0]          v0_y,
    input  logic signed [COORD_WIDTH-1:0]          v0_z,
    input  logic signed [COORD_WIDTH-1:0]          v1_x,
    input  logic signed [COORD_WIDTH-1:0]          v1_y,
    input  logic signed [COORD_WIDTH-1:0]          v1_z,
    input  logic signed [COORD_WIDTH-1:0]          v2_x,
    input  logic signed [COORD_WIDTH-1:0]          v2_y,
    input  logic signed [COORD_WIDTH-1:0]          v2_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tps_pkg::NORM_W-1:0]      normal_x,
    output logic signed [tps_pkg::NORM_W-1:0]      normal_y,
    output logic signed [tps_pkg::NORM_W-1:0]      normal_z,
    output logic [tps_pkg::AXIS_W-1:0]             proj_u,
    output logic [tps_pkg::AXIS_W-1:0]             proj_v,
    output logic signed [tps_pkg::INV_W-1:0]       inv_m00,
    output logic signed [tps_pkg::INV_W-1:0]       inv_m01,
    output logic signed [tps_pkg::INV_W-1:0]       inv_m10,
    output logic signed [tps_pkg::INV_W-1:0]       inv_m11,
    output logic                                   degenerate
);

    localparam int EW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int BLW = $clog2(PW + 1);
    localparam int DWI = PW + 1;
    localparam int NIW = DWI + tps_pkg::INV_QB;
    localparam int DWN = tps_pkg::ROOT_W + 1;
    localparam int NNW = DWN + tps_pkg::NORM_QB;
    localparam int AW  = tps_pkg::AXIS_W;
    localparam int SMW = tps_pkg::SM_W;
    localparam int QN  = tps_pkg::NORM_QB;
    localparam int QI  = tps_pkg::INV_QB;
    localparam int IW  = tps_pkg::INV_W;
    localparam int OW  = tps_pkg::NORM_W;

    typedef struct packed {
        logic [2:0][SMW-1:0] sm;
        logic [3:0][NIW-1:0] inum;
        logic [DWI-1:0]      iden;
        logic [3:0]          ineg;
        logic [2:0]          nsign;
        logic [AW-1:0]       u;
        logic [AW-1:0]       v;
        logic                deg;
    } sq_side_t;

    typedef struct packed {
        logic [3:0][NIW-1:0] inum;
        logic [DWI-1:0]      iden;
        logic [3:0]          ineg;
        logic [2:0]          nsign;
        logic [AW-1:0]       u;
        logic [AW-1:0]       v;
        logic                deg;
    } nd_side_t;

    typedef struct packed {
        logic [2:0][QN-1:0]  nq;
        logic [3:0]          ineg;
        logic [2:0]          nsign;
        logic [AW-1:0]       u;
        logic [AW-1:0]       v;
        logic                deg;
    } iv_side_t;

    localparam int SQ_SW = $bits(sq_side_t);
    localparam int ND_SW = $bits(nd_side_t);
    localparam int IV_SW = $bits(iv_side_t);

    function automatic logic [EW-1:0] mag_e(input logic signed [EW-1:0] x);
        mag_e = x[EW-1] ? EW'(-x) : EW'(x);
    endfunction

    function automatic logic [IW-1:0] sat_entry(input logic [QI-1:0] q, input logic neg);
        logic [IW-1:0] lim;
        logic [IW-1:0] m;
        lim = neg ? tps_pkg::INV_NEG_LIM : tps_pkg::INV_POS_LIM;
        m   = (q > QI'(lim)) ? lim : q[IW-1:0];
        sat_entry = neg ? IW'(-m) : m;
    endfunction

    logic out_valid_reg;
    logic advance;
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // stage 1: edges from vertex 0
    logic                 s1_valid_reg;
    logic signed [EW-1:0] s1_e0_reg [3];
    logic signed [EW-1:0] s1_e1_reg [3];
    logic signed [EW-1:0] s1_e0_next [3];
    logic signed [EW-1:0] s1_e1_next [3];

    always_comb
    begin
        s1_e0_next[0] = EW'(v1_x) - EW'(v0_x);
        s1_e0_next[1] = EW'(v1_y) - EW'(v0_y);
        s1_e0_next[2] = EW'(v1_z) - EW'(v0_z);
        s1_e1_next[0] = EW'(v2_x) - EW'(v0_x);
        s1_e1_next[1] = EW'(v2_y) - EW'(v0_y);
        s1_e1_next[2] = EW'(v2_z) - EW'(v0_z);
    end

    // stage 2: cross product terms
    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_p_reg [6];
    logic signed [PW-1:0] s2_p_next [6];
    logic signed [EW-1:0] s2_e0_reg [3];
    logic signed [EW-1:0] s2_e1_reg [3];

    always_comb
    begin
        s2_p_next[0] = PW'(s1_e0_reg[1]) * PW'(s1_e1_reg[2]);
        s2_p_next[1] = PW'(s1_e0_reg[2]) * PW'(s1_e1_reg[1]);
        s2_p_next[2] = PW'(s1_e0_reg[2]) * PW'(s1_e1_reg[0]);
        s2_p_next[3] = PW'(s1_e0_reg[0]) * PW'(s1_e1_reg[2]);
        s2_p_next[4] = PW'(s1_e0_reg[0]) * PW'(s1_e1_reg[1]);
        s2_p_next[5] = PW'(s1_e0_reg[1]) * PW'(s1_e1_reg[0]);
    end

    // stage 3: normal, magnitudes and signs
    logic                 s3_valid_reg;
    logic [PW-1:0]        s3_an_reg [3];
    logic [2:0]           s3_nsign_reg;
    logic signed [EW-1:0] s3_e0_reg [3];
    logic signed [EW-1:0] s3_e1_reg [3];
    logic [PW-1:0]        s3_an_next [3];
    logic [2:0]           s3_nsign_next;

    always_comb
    begin
        logic signed [NW-1:0] n;
        n = '0;
        for (int i = 0; i < 3; i++)
        begin
            n = NW'(s2_p_reg[2*i]) - NW'(s2_p_reg[2*i+1]);
            s3_nsign_next[i] = n[NW-1];
            s3_an_next[i]    = n[NW-1] ? PW'(-n) : PW'(n);
        end
    end

    // stage 4: dominant axis, ties keep the lower axis
    logic                 s4_valid_reg;
    logic [PW-1:0]        s4_an_reg [3];
    logic [PW-1:0]        s4_m_reg;
    logic [2:0]           s4_nsign_reg;
    logic [AW-1:0]        s4_u_reg;
    logic [AW-1:0]        s4_v_reg;
    logic signed [EW-1:0] s4_a_reg;
    logic signed [EW-1:0] s4_b_reg;
    logic signed [EW-1:0] s4_c_reg;
    logic signed [EW-1:0] s4_d_reg;
    logic [PW-1:0]        s4_m_next;
    logic [AW-1:0]        s4_u_next;
    logic [AW-1:0]        s4_v_next;
    logic signed [EW-1:0] s4_a_next;
    logic signed [EW-1:0] s4_b_next;
    logic signed [EW-1:0] s4_c_next;
    logic signed [EW-1:0] s4_d_next;

    always_comb
    begin
        logic [AW-1:0] ax;
        ax = tps_pkg::AXIS_X;
        if (s3_an_reg[1] > s3_an_reg[0])
            ax = tps_pkg::AXIS_Y;
        if (s3_an_reg[2] > ((ax == tps_pkg::AXIS_Y) ? s3_an_reg[1] : s3_an_reg[0]))
            ax = tps_pkg::AXIS_Z;
        unique case (ax)
            tps_pkg::AXIS_X:
            begin
                s4_m_next = s3_an_reg[0];
                s4_u_next = tps_pkg::AXIS_Y;
                s4_v_next = tps_pkg::AXIS_Z;
                s4_a_next = s3_e0_reg[1];
                s4_b_next = s3_e1_reg[1];
                s4_c_next = s3_e0_reg[2];
                s4_d_next = s3_e1_reg[2];
            end
            tps_pkg::AXIS_Y:
            begin
                s4_m_next = s3_an_reg[1];
                s4_u_next = tps_pkg::AXIS_X;
                s4_v_next = tps_pkg::AXIS_Z;
                s4_a_next = s3_e0_reg[0];
                s4_b_next = s3_e1_reg[0];
                s4_c_next = s3_e0_reg[2];
                s4_d_next = s3_e1_reg[2];
            end
            default:
            begin
                s4_m_next = s3_an_reg[2];
                s4_u_next = tps_pkg::AXIS_X;
                s4_v_next = tps_pkg::AXIS_Y;
                s4_a_next = s3_e0_reg[0];
                s4_b_next = s3_e1_reg[0];
                s4_c_next = s3_e0_reg[1];
                s4_d_next = s3_e1_reg[1];
            end
        endcase
    end

    // stage 5: determinant terms and normalising shift
    logic                 s5_valid_reg;
    logic signed [PW-1:0] s5_ad_reg;
    logic signed [PW-1:0] s5_bc_reg;
    logic [BLW-1:0]       s5_sh_reg;
    logic                 s5_nzero_reg;
    logic [PW-1:0]        s5_an_reg [3];
    logic [2:0]           s5_nsign_reg;
    logic [AW-1:0]        s5_u_reg;
    logic [AW-1:0]        s5_v_reg;
    logic signed [EW-1:0] s5_a_reg;
    logic signed [EW-1:0] s5_b_reg;
    logic signed [EW-1:0] s5_c_reg;
    logic signed [EW-1:0] s5_d_reg;
    logic [BLW-1:0]       s5_sh_next;

    always_comb
    begin
        logic [BLW-1:0] bl;
        bl = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (s4_m_reg[i])
                bl = BLW'(i + 1);
        end
        s5_sh_next = (bl > BLW'(SMW)) ? BLW'(bl - BLW'(SMW)) : '0;
    end

    // stage 6: determinant and shifted magnitudes
    logic                 s6_valid_reg;
    logic signed [NW-1:0] s6_det_reg;
    logic [SMW-1:0]       s6_sm_reg [3];
    logic                 s6_nzero_reg;
    logic [2:0]           s6_nsign_reg;
    logic [AW-1:0]        s6_u_reg;
    logic [AW-1:0]        s6_v_reg;
    logic signed [EW-1:0] s6_a_reg;
    logic signed [EW-1:0] s6_b_reg;
    logic signed [EW-1:0] s6_c_reg;
    logic signed [EW-1:0] s6_d_reg;

    // stage 7: squares, |det| and entry signs
    logic                   s7_valid_reg;
    logic [tps_pkg::SUM_W-1:0] s7_sq_reg [3];
    logic [PW-1:0]          s7_adet_reg;
    logic                   s7_dzero_reg;
    logic                   s7_nzero_reg;
    logic [3:0][EW-1:0]     s7_mag_reg;
    logic [3:0]             s7_ineg_reg;
    logic [2:0]             s7_nsign_reg;
    logic [AW-1:0]          s7_u_reg;
    logic [AW-1:0]          s7_v_reg;
    // magnitudes ride alongside the squares through stage 7
    logic [SMW-1:0]         s7_sm_reg [3];
    logic                   s6_dneg;

    assign s6_dneg = s6_det_reg[NW-1];

    // stage 8: sum of squares and divider operands
    logic                   s8_valid_reg;
    logic [tps_pkg::SUM_W-1:0] s8_sum_reg;
    sq_side_t               s8_side_reg;
    sq_side_t               s8_side_next;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            s8_side_next.inum[j] = (NIW'(s7_mag_reg[j]) << tps_pkg::INV_SHIFT)
                                   + NIW'(s7_adet_reg);
        for (int i = 0; i < 3; i++)
            s8_side_next.sm[i] = s7_sm_reg[i];
        s8_side_next.iden  = {s7_adet_reg, 1'b0};
        s8_side_next.ineg  = s7_ineg_reg;
        s8_side_next.nsign = s7_nsign_reg;
        s8_side_next.u     = s7_u_reg;
        s8_side_next.v     = s7_v_reg;
        s8_side_next.deg   = s7_nzero_reg || s7_dzero_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    // setup payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s1_e0_reg <= s1_e0_next;
            s1_e1_reg <= s1_e1_next;
        end
        if (advance && s1_valid_reg)
        begin
            s2_p_reg  <= s2_p_next;
            s2_e0_reg <= s1_e0_reg;
            s2_e1_reg <= s1_e1_reg;
        end
        if (advance && s2_valid_reg)
        begin
            s3_an_reg    <= s3_an_next;
            s3_nsign_reg <= s3_nsign_next;
            s3_e0_reg    <= s2_e0_reg;
            s3_e1_reg    <= s2_e1_reg;
        end
        if (advance && s3_valid_reg)
        begin
            s4_an_reg    <= s3_an_reg;
            s4_nsign_reg <= s3_nsign_reg;
            s4_m_reg     <= s4_m_next;
            s4_u_reg     <= s4_u_next;
            s4_v_reg     <= s4_v_next;
            s4_a_reg     <= s4_a_next;
            s4_b_reg     <= s4_b_next;
            s4_c_reg     <= s4_c_next;
            s4_d_reg     <= s4_d_next;
        end
        if (advance && s4_valid_reg)
        begin
            s5_ad_reg    <= PW'(s4_a_reg) * PW'(s4_d_reg);
            s5_bc_reg    <= PW'(s4_b_reg) * PW'(s4_c_reg);
            s5_sh_reg    <= s5_sh_next;
            s5_nzero_reg <= (s4_m_reg == '0);
            s5_an_reg    <= s4_an_reg;
            s5_nsign_reg <= s4_nsign_reg;
            s5_u_reg     <= s4_u_reg;
            s5_v_reg     <= s4_v_reg;
            s5_a_reg     <= s4_a_reg;
            s5_b_reg     <= s4_b_reg;
            s5_c_reg     <= s4_c_reg;
            s5_d_reg     <= s4_d_reg;
        end
        if (advance && s5_valid_reg)
        begin
            s6_det_reg   <= NW'(s5_ad_reg) - NW'(s5_bc_reg);
            for (int i = 0; i < 3; i++)
                s6_sm_reg[i] <= SMW'(s5_an_reg[i] >> s5_sh_reg);
            s6_nzero_reg <= s5_nzero_reg;
            s6_nsign_reg <= s5_nsign_reg;
            s6_u_reg     <= s5_u_reg;
            s6_v_reg     <= s5_v_reg;
            s6_a_reg     <= s5_a_reg;
            s6_b_reg     <= s5_b_reg;
            s6_c_reg     <= s5_c_reg;
            s6_d_reg     <= s5_d_reg;
        end
        if (advance && s6_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_sq_reg[i] <= tps_pkg::SUM_W'(s6_sm_reg[i]) * tps_pkg::SUM_W'(s6_sm_reg[i]);
                s7_sm_reg[i] <= s6_sm_reg[i];
            end
            s7_adet_reg  <= s6_dneg ? PW'(-s6_det_reg) : PW'(s6_det_reg);
            s7_dzero_reg <= (s6_det_reg == '0);
            s7_nzero_reg <= s6_nzero_reg;
            // entries d, -b, -c, a over det; a zero numerator gives zero anyway
            s7_mag_reg[0]  <= mag_e(s6_d_reg);
            s7_mag_reg[1]  <= mag_e(s6_b_reg);
            s7_mag_reg[2]  <= mag_e(s6_c_reg);
            s7_mag_reg[3]  <= mag_e(s6_a_reg);
            s7_ineg_reg[0] <= s6_d_reg[EW-1] ^ s6_dneg;
            s7_ineg_reg[1] <= !s6_b_reg[EW-1] ^ s6_dneg;
            s7_ineg_reg[2] <= !s6_c_reg[EW-1] ^ s6_dneg;
            s7_ineg_reg[3] <= s6_a_reg[EW-1] ^ s6_dneg;
            s7_nsign_reg   <= s6_nsign_reg;
            s7_u_reg       <= s6_u_reg;
            s7_v_reg       <= s6_v_reg;
        end
        if (advance && s7_valid_reg)
        begin
            s8_sum_reg  <= s7_sq_reg[0] + s7_sq_reg[1] + s7_sq_reg[2];
            s8_side_reg <= s8_side_next;
        end
    end

    // vector length
    tps_pkg::pipe_ctl_t            sq_ctl;
    logic                          sq_valid;
    logic [tps_pkg::ROOT_W-1:0]    sq_root;
    logic [SQ_SW-1:0]              sq_side_vec;
    sq_side_t                      sq_side;

    assign sq_ctl.advance = advance;
    assign sq_ctl.valid   = s8_valid_reg;
    assign sq_side        = sq_side_vec;

    tps_sqrt_pipe #(
        .SW (SQ_SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (s8_sum_reg),
        .side      (s8_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side_vec)
    );

    // normal components: (2*sm*16384 + L) / (2*L)
    tps_pkg::pipe_ctl_t     nd_ctl;
    logic [2:0][NNW-1:0]    nd_num;
    logic [2:0][DWN-1:0]    nd_den;
    nd_side_t               nd_side_in;
    logic                   nd_valid;
    logic [2:0][QN-1:0]     nd_quo;
    logic [ND_SW-1:0]       nd_side_vec;
    nd_side_t               nd_side;

    assign nd_ctl.advance = advance;
    assign nd_ctl.valid   = sq_valid;
    assign nd_side        = nd_side_vec;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd_num[i] = (NNW'(sq_side.sm[i]) << (tps_pkg::NORM_FRAC + 1)) + NNW'(sq_root);
            nd_den[i] = {sq_root, 1'b0};
        end
        nd_side_in.inum  = sq_side.inum;
        nd_side_in.iden  = sq_side.iden;
        nd_side_in.ineg  = sq_side.ineg;
        nd_side_in.nsign = sq_side.nsign;
        nd_side_in.u     = sq_side.u;
        nd_side_in.v     = sq_side.v;
        nd_side_in.deg   = sq_side.deg;
    end

    tps_div_pipe #(
        .LANES (3),
        .DW    (DWN),
        .QB    (QN),
        .SW    (ND_SW)
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (nd_ctl),
        .num       (nd_num),
        .den       (nd_den),
        .side      (nd_side_in),
        .out_valid (nd_valid),
        .quo       (nd_quo),
        .side_out  (nd_side_vec)
    );

    // inverse matrix entries: (|num|*2^33 + |det|) / (2*|det|), saturated to the signed 32-bit range
    tps_pkg::pipe_ctl_t     iv_ctl;
    logic [3:0][DWI-1:0]    iv_den;
    iv_side_t               iv_side_in;
    logic                   iv_valid;
    logic [3:0][QI-1:0]     iv_quo;
    logic [IV_SW-1:0]       iv_side_vec;
    iv_side_t               iv_side;

    assign iv_ctl.advance = advance;
    assign iv_ctl.valid   = nd_valid;
    assign iv_side        = iv_side_vec;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            iv_den[j] = nd_side.iden;
        iv_side_in.nq    = nd_quo;
        iv_side_in.ineg  = nd_side.ineg;
        iv_side_in.nsign = nd_side.nsign;
        iv_side_in.u     = nd_side.u;
        iv_side_in.v     = nd_side.v;
        iv_side_in.deg   = nd_side.deg;
    end

    tps_div_pipe #(
        .LANES (4),
        .DW    (DWI),
        .QB    (QI),
        .SW    (IV_SW)
    ) u_inv_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (iv_ctl),
        .num       (nd_side.inum),
        .den       (iv_den),
        .side      (iv_side_in),
        .out_valid (iv_valid),
        .quo       (iv_quo),
        .side_out  (iv_side_vec)
    );

    // output register
    logic signed [OW-1:0] normal_x_reg;
    logic signed [OW-1:0] normal_y_reg;
    logic signed [OW-1:0] normal_z_reg;
    logic [AW-1:0]        proj_u_reg;
    logic [AW-1:0]        proj_v_reg;
    logic signed [IW-1:0] inv_m00_reg;
    logic signed [IW-1:0] inv_m01_reg;
    logic signed [IW-1:0] inv_m10_reg;
    logic signed [IW-1:0] inv_m11_reg;
    logic                 degenerate_reg;
    logic [OW-1:0]        nrm_next [3];
    logic [IW-1:0]        inv_next [4];

    always_comb
    begin
        logic [OW-1:0] q;
        q = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = OW'(iv_side.nq[i]);
            nrm_next[i] = iv_side.deg ? '0 : (iv_side.nsign[i] ? OW'(-q) : q);
        end
        for (int j = 0; j < 4; j++)
            inv_next[j] = iv_side.deg ? '0 : sat_entry(iv_quo[j], iv_side.ineg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= iv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && iv_valid)
        begin
            normal_x_reg   <= nrm_next[0];
            normal_y_reg   <= nrm_next[1];
            normal_z_reg   <= nrm_next[2];
            proj_u_reg     <= iv_side.u;
            proj_v_reg     <= iv_side.v;
            inv_m00_reg    <= inv_next[0];
            inv_m01_reg    <= inv_next[1];
            inv_m10_reg    <= inv_next[2];
            inv_m11_reg    <= inv_next[3];
            degenerate_reg <= iv_side.deg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;
    assign normal_z   = normal_z_reg;
    assign proj_u     = proj_u_reg;
    assign proj_v     = proj_v_reg;
    assign inv_m00    = inv_m00_reg;
    assign inv_m01    = inv_m01_reg;
    assign inv_m10    = inv_m10_reg;
    assign inv_m11    = inv_m11_reg;
    assign degenerate = degenerate_reg;

    logic nrm_zero;
    logic inv_zero;
    logic axes_ok;

    assign nrm_zero = normal_x_reg == 0 && normal_y_reg == 0 && normal_z_reg == 0;
    assign inv_zero = inv_m00_reg == 0 && inv_m01_reg == 0 && inv_m10_reg == 0
                      && inv_m11_reg == 0;
    assign axes_ok  = proj_u_reg < proj_v_reg && proj_v_reg <= tps_pkg::AXIS_Z;

    `TPS_ASSERT_IMPLY(a_degenerate_zeroes, clk, rst_n, out_valid_reg && degenerate_reg, nrm_zero && inv_zero)
    `TPS_ASSERT_IMPLY(a_axes_ordered, clk, rst_n, out_valid_reg, axes_ok)
    `TPS_ASSERT_IMPLY(a_normal_nonzero, clk, rst_n, out_valid_reg && !degenerate_reg, !nrm_zero)
    `TPS_ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, iv_valid && !advance, iv_valid)

endmodule
`default_nettype wire
